### hdl/sha1_hash_engine_top_assert.svh
// Assertion macros for the SHA-1 engine. They expect clk and rst_n in scope.
`ifndef SHA1_HASH_ENGINE_TOP_ASSERT_SVH
`define SHA1_HASH_ENGINE_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SHA1HE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SHA1HE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/sha1he_pkg.sv
`timescale 1ns / 1ps

package sha1he_pkg;

    localparam int unsigned ROUNDS       = 80;
    localparam int unsigned ROUND_W      = 7;
    localparam int unsigned BLOCK_BYTES  = 64;
    localparam int unsigned FILL_W       = 6;
    localparam int unsigned SCHED_WORDS  = 16;
    localparam int unsigned DIGEST_WORDS = 5;
    localparam int unsigned IDX_W        = 3;
    localparam int unsigned LEN_OFFSET   = 56;
    localparam int unsigned LEN_W        = 64;

    typedef logic [31:0] word_t;

    // Initial chaining values.
    localparam word_t SHA1_IV [DIGEST_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    // Round constants, one per group of twenty rounds.
    localparam word_t K_0 = 32'h5A827999;
    localparam word_t K_1 = 32'h6ED9EBA1;
    localparam word_t K_2 = 32'h8F1BBCDC;
    localparam word_t K_3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // Control toward the round unit.
    typedef struct packed {
        logic load;   // copy chaining words into the working registers
        logic step;   // run one round
        logic fold;   // add working registers into the chaining words
        logic init;   // restore the initial chaining values
    } round_ctrl_t;

    // Control toward the message schedule.
    typedef struct packed {
        logic byte_wr;    // shift one byte into the word assembler
        logic word_done;  // this byte completes a 32-bit word
        logic step;       // expand one schedule word
    } sched_ctrl_t;

    // Boolean function of a round.
    function automatic word_t sha1_f(logic [ROUND_W-1:0] r, word_t b, word_t c, word_t d);
        word_t f;
        if (r < ROUND_W'(20)) begin
            f = (b & c) | (~b & d);
        end
        else if (r < ROUND_W'(40)) begin
            f = b ^ c ^ d;
        end
        else if (r < ROUND_W'(60)) begin
            f = (b & c) | (b & d) | (c & d);
        end
        else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

    // Additive constant of a round.
    function automatic word_t sha1_k(logic [ROUND_W-1:0] r);
        word_t k;
        if (r < ROUND_W'(20)) begin
            k = K_0;
        end
        else if (r < ROUND_W'(40)) begin
            k = K_1;
        end
        else if (r < ROUND_W'(60)) begin
            k = K_2;
        end
        else begin
            k = K_3;
        end
        return k;
    endfunction

endpackage

### hdl/sha1he_sched.sv
`timescale 1ns / 1ps

module sha1he_sched
    import sha1he_pkg::*;
(
    input  logic        clk,
    input  sched_ctrl_t ctrl,
    input  logic [7:0]  byte_val,
    output word_t       w_cur
);

    logic [23:0] asm_reg;
    word_t       w_reg [SCHED_WORDS];
    word_t       shift_in;
    word_t       expand;

    // Next schedule word from the sixteen-word window.
    assign expand = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];

    always_comb
    begin
        if (ctrl.byte_wr) begin
            shift_in = {asm_reg, byte_val};
        end
        else begin
            shift_in = {expand[30:0], expand[31]};
        end
    end

    // Byte assembler and the schedule window. During loading the window
    // collects the block big-endian; during rounds it slides one word a cycle.
    always_ff @(posedge clk)
    begin
        if (ctrl.byte_wr) begin
            asm_reg <= {asm_reg[15:0], byte_val};
        end
        if ((ctrl.byte_wr && ctrl.word_done) || ctrl.step) begin
            for (int i = 0; i < SCHED_WORDS - 1; i++) begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[SCHED_WORDS-1] <= shift_in;
        end
    end

    assign w_cur = w_reg[0];

endmodule

### hdl/sha1he_round.sv
`timescale 1ns / 1ps

module sha1he_round
    import sha1he_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  round_ctrl_t        ctrl,
    input  logic [ROUND_W-1:0] round_idx,
    input  word_t              w_cur,
    input  logic [IDX_W-1:0]   rd_sel,
    output word_t              rd_word
);

    word_t a_reg, b_reg, c_reg, d_reg, e_reg;
    word_t t_next;
    word_t h_reg [DIGEST_WORDS];

    // One SHA-1 round: the shared adder tree.
    assign t_next = {a_reg[26:0], a_reg[31:27]} + sha1_f(round_idx, b_reg, c_reg, d_reg)
                  + e_reg + sha1_k(round_idx) + w_cur;

    // Working registers.
    always_ff @(posedge clk)
    begin
        if (ctrl.load) begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
        end
        else if (ctrl.step) begin
            a_reg <= t_next;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    // Chaining words.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < DIGEST_WORDS; i++) begin
                h_reg[i] <= SHA1_IV[i];
            end
        end
        else if (ctrl.init) begin
            for (int i = 0; i < DIGEST_WORDS; i++) begin
                h_reg[i] <= SHA1_IV[i];
            end
        end
        else if (ctrl.fold) begin
            h_reg[0] <= h_reg[0] + a_reg;
            h_reg[1] <= h_reg[1] + b_reg;
            h_reg[2] <= h_reg[2] + c_reg;
            h_reg[3] <= h_reg[3] + d_reg;
            h_reg[4] <= h_reg[4] + e_reg;
        end
    end

    // Digest read port.
    always_comb
    begin
        case (rd_sel)
            3'd0:    rd_word = h_reg[0];
            3'd1:    rd_word = h_reg[1];
            3'd2:    rd_word = h_reg[2];
            3'd3:    rd_word = h_reg[3];
            3'd4:    rd_word = h_reg[4];
            default: rd_word = h_reg[0];
        endcase
    end

endmodule

### hdl/sha1_hash_engine_top.sv
`timescale 1ns / 1ps
`include "sha1_hash_engine_top_assert.svh"

// Byte-serial SHA-1 engine. Each input transaction may carry one message byte
// (tuser high) and may close the message (tlast high). A byte that does not
// complete a 64-byte block is taken without stalling the input. The byte that
// completes a block starts the compression, which runs on one shared round
// unit at one round per cycle; the input stalls through the rounds and the
// add into the chaining words. Closing a message feeds the padding and the
// bit length through the same byte path, one byte per cycle, up to the end of
// the block, then compresses; when fewer than nine bytes were left in the
// block, a second padding block follows. The digest then leaves as five output
// transactions, most significant word first, with the word position in tuser
// and tlast on the fifth word; the next message starts after the fifth word
// is taken. The worst case from closing transaction to first digest word is
// when the marker byte lands at offset 56 and a second padding block follows.
module sha1_hash_engine_top
    import sha1he_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // [7:0] data_byte
    input  logic             s_axis_tuser,   // [0] has_byte
    input  logic             s_axis_tlast,   // end_of_message
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] digest_word
    output logic [IDX_W-1:0] m_axis_tuser,   // [2:0] word_index
    output logic             m_axis_tlast    // last_word
);

    localparam logic [FILL_W-1:0]  FILL_LAST  = FILL_W'(BLOCK_BYTES - 1);
    localparam logic [FILL_W-1:0]  FILL_LEN   = FILL_W'(LEN_OFFSET);
    localparam logic [ROUND_W-1:0] ROUND_LAST = ROUND_W'(ROUNDS - 1);
    localparam logic [IDX_W-1:0]   IDX_LAST   = IDX_W'(DIGEST_WORDS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_FOLD,
        ST_OUT
    } state_t;

    state_t             state_reg, state_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [ROUND_W-1:0] round_reg, round_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               fin_reg, fin_next;       // message is being closed
    logic               final_reg, final_next;   // block in flight is the last one
    logic               first_reg, first_next;   // next padding byte is the marker
    logic               len_ok_reg, len_ok_next; // length may go in this block

    round_ctrl_t rctrl;
    sched_ctrl_t sctrl;
    logic [7:0]  byte_val;
    logic [7:0]  len_byte;
    word_t       w_cur;
    word_t       rd_word;
    logic        in_acc;
    logic        out_acc;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    // Length byte for the tail of the final block, most significant first.
    assign len_byte = len_reg[{~fill_reg[2:0], 3'b000} +: 8];

    // Sequencer next-state logic.
    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        len_next    = len_reg;
        round_next  = round_reg;
        idx_next    = idx_reg;
        fin_next    = fin_reg;
        final_next  = final_reg;
        first_next  = first_reg;
        len_ok_next = len_ok_reg;
        rctrl       = '0;
        sctrl       = '0;
        byte_val    = s_axis_tdata;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc) begin
                    if (s_axis_tuser) begin
                        sctrl.byte_wr = 1'b1;
                        fill_next     = fill_reg + FILL_W'(1);
                        len_next      = len_reg + LEN_W'(8);
                        if (fill_reg == FILL_LAST) begin
                            rctrl.load = 1'b1;
                            round_next = '0;
                            fin_next   = s_axis_tlast;
                            final_next = 1'b0;
                            first_next = s_axis_tlast;
                            state_next = ST_COMP;
                        end
                        else if (s_axis_tlast) begin
                            fin_next   = 1'b1;
                            first_next = 1'b1;
                            state_next = ST_PAD;
                        end
                    end
                    else if (s_axis_tlast) begin
                        fin_next   = 1'b1;
                        first_next = 1'b1;
                        state_next = ST_PAD;
                    end
                end
            end

            ST_PAD:
            begin
                sctrl.byte_wr = 1'b1;
                fill_next     = fill_reg + FILL_W'(1);
                if (first_reg) begin
                    byte_val    = PAD_BYTE;
                    first_next  = 1'b0;
                    len_ok_next = (fill_reg < FILL_LEN);
                end
                else if (len_ok_reg && fill_reg >= FILL_LEN) begin
                    byte_val = len_byte;
                end
                else begin
                    byte_val = 8'h00;
                end
                if (fill_reg == FILL_LAST) begin
                    rctrl.load = 1'b1;
                    round_next = '0;
                    final_next = first_reg ? 1'b0 : len_ok_reg;
                    state_next = ST_COMP;
                end
            end

            ST_COMP:
            begin
                rctrl.step = 1'b1;
                sctrl.step = 1'b1;
                round_next = round_reg + ROUND_W'(1);
                if (round_reg == ROUND_LAST) begin
                    state_next = ST_FOLD;
                end
            end

            ST_FOLD:
            begin
                rctrl.fold  = 1'b1;
                len_ok_next = 1'b1;
                if (!fin_reg) begin
                    state_next = ST_IDLE;
                end
                else if (final_reg) begin
                    idx_next   = '0;
                    state_next = ST_OUT;
                end
                else begin
                    state_next = ST_PAD;
                end
            end

            ST_OUT:
            begin
                if (out_acc) begin
                    idx_next = idx_reg + IDX_W'(1);
                    if (idx_reg == IDX_LAST) begin
                        rctrl.init = 1'b1;
                        len_next   = '0;
                        fill_next  = '0;
                        fin_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        sctrl.word_done = (fill_reg[1:0] == 2'b11);
    end

    // Sequencer state and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            len_reg    <= '0;
            round_reg  <= '0;
            idx_reg    <= '0;
            fin_reg    <= 1'b0;
            final_reg  <= 1'b0;
            first_reg  <= 1'b0;
            len_ok_reg <= 1'b1;
        end
        else begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            len_reg    <= len_next;
            round_reg  <= round_next;
            idx_reg    <= idx_next;
            fin_reg    <= fin_next;
            final_reg  <= final_next;
            first_reg  <= first_next;
            len_ok_reg <= len_ok_next;
        end
    end

    // Message schedule.
    sha1he_sched u_sched (
        .clk      (clk),
        .ctrl     (sctrl),
        .byte_val (byte_val),
        .w_cur    (w_cur)
    );

    // Shared round unit and chaining words.
    sha1he_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (rctrl),
        .round_idx (round_reg),
        .w_cur     (w_cur),
        .rd_sel    (idx_reg),
        .rd_word   (rd_word)
    );

    // Stream handshakes and digest output.
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = rd_word;
    assign m_axis_tuser  = idx_reg;
    assign m_axis_tlast  = (idx_reg == IDX_LAST);

    // Checks on the sequencer.
    `SHA1HE_ASSERT_NOW(a_no_overlap, 1'b1, !(s_axis_tready && m_axis_tvalid),
        "input and output both active")
    `SHA1HE_ASSERT_NOW(a_round_range, state_reg == ST_COMP, round_reg <= ROUND_LAST,
        "round counter out of range")
    `SHA1HE_ASSERT_NEXT(a_block_full, state_reg == ST_PAD && fill_reg == FILL_LAST,
        state_reg == ST_COMP && round_reg == '0,
        "full padding block did not start compression")
    `SHA1HE_ASSERT_NEXT(a_restart, out_acc && m_axis_tlast,
        s_axis_tready && fill_reg == '0 && len_reg == '0,
        "engine not reinitialized after digest")

endmodule

### dv/sha1_hash_engine_top_test.sv
`timescale 1ns / 1ps

module sha1_hash_engine_top_test;
    import sha1he_pkg::*;

    localparam int unsigned ITEM_TARGET  = 360;
    localparam int unsigned QUIET_LIMIT  = 4000;
    localparam int unsigned DRAIN_CYCLES = 300;
    localparam int unsigned NUM_ROWS     = 14;

    // Published digests of the empty message and of "abc".
    localparam logic [159:0] EMPTY_DIGEST = 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709;
    localparam logic [159:0] ABC_DIGEST   = 160'ha9993e364706816aba3e25717850c26c9cd0d89d;

    // One digest word as it should leave the engine.
    typedef struct packed {
        word_t            word;
        logic [IDX_W-1:0] pos;
        logic             last;
    } digest_word_t;

    // One directed input transaction, with a known digest where one is typed in.
    typedef struct packed {
        logic [7:0]   data;
        logic         has_byte;
        logic         end_msg;
        logic         known;
        logic [159:0] digest;
    } stim_row_t;

    // Directed rows: idle and ignored bytes, empty message, "abc", byte extremes,
    // closing without a byte, and an empty message right after a digest.
    localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
        '{8'h5A, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
        '{8'h61, 1'b1, 1'b0, 1'b0, '0},
        '{8'h62, 1'b1, 1'b0, 1'b0, '0},
        '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},
        '{8'h00, 1'b1, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b1, 1'b1, 1'b0, '0},
        '{8'h80, 1'b1, 1'b0, 1'b0, '0},
        '{8'h55, 1'b0, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b1, 1'b0, '0},
        '{8'hFF, 1'b1, 1'b0, 1'b0, '0},
        '{8'hAA, 1'b0, 1'b1, 1'b0, '0},
        '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
        '{8'h61, 1'b1, 1'b1, 1'b0, '0}
    };

    logic             clk;
    logic             rst_n         = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata  = '0;   // [7:0] data_byte
    logic             s_axis_tuser  = 1'b0; // [0] has_byte
    logic             s_axis_tlast  = 1'b0; // end_of_message
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [31:0]      m_axis_tdata;         // [31:0] digest_word
    logic [IDX_W-1:0] m_axis_tuser;         // [2:0] word_index
    logic             m_axis_tlast;         // last_word

    // Hash state of the predictor.
    word_t       hash_state [DIGEST_WORDS];
    logic [7:0]  block_buf [BLOCK_BYTES];
    int unsigned buf_fill;
    logic [63:0] msg_bits;

    digest_word_t pending_words [$];
    int unsigned  error_count   = 0;
    int unsigned  words_checked = 0;
    int unsigned  items_sent    = 0;
    int unsigned  digests_due   = 0;
    int unsigned  quiet_cycles  = 0;
    int unsigned  src_idle_pct  = 0;
    int unsigned  snk_stall_pct = 0;

    sha1_hash_engine_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic word_t rotl(input word_t x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // Restore the initial chaining values and clear the length.
    function automatic void sha1_restart();
        int unsigned i;
        for (i = 0; i < DIGEST_WORDS; i++)
        begin
            hash_state[i] = SHA1_IV[i];
        end
        buf_fill = 0;
        msg_bits = '0;
    endfunction

    // Run the 80-round compression over the block buffer.
    function automatic void pred_block_rounds();
        word_t       w [80];
        word_t       a, b, c, d, e, f, k, t;
        int unsigned r;
        for (r = 0; r < 16; r++)
        begin
            w[r] = {block_buf[4*r], block_buf[4*r+1], block_buf[4*r+2], block_buf[4*r+3]};
        end
        for (r = 16; r < 80; r++)
        begin
            w[r] = rotl(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
        end
        a = hash_state[0];
        b = hash_state[1];
        c = hash_state[2];
        d = hash_state[3];
        e = hash_state[4];
        for (r = 0; r < 80; r++)
        begin
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = K_0;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = K_1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = K_2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = K_3;
            end
            t = rotl(a, 5) + f + e + k + w[r];
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
        end
        hash_state[0] += a;
        hash_state[1] += b;
        hash_state[2] += c;
        hash_state[3] += d;
        hash_state[4] += e;
    endfunction

    // Absorb one input transaction; returns 1 with the digest when the message closes.
    function automatic bit sha1_take_item(input logic [7:0] data, input logic has_byte,
                                          input logic end_msg, output logic [159:0] digest);
        int unsigned i;
        digest = '0;
        if (has_byte)
        begin
            block_buf[buf_fill] = data;
            buf_fill++;
            msg_bits += 64'd8;
            if (buf_fill == BLOCK_BYTES)
            begin
                pred_block_rounds();
                buf_fill = 0;
            end
        end
        if (!end_msg)
        begin
            return 1'b0;
        end
        // Padding: marker byte, zero fill, then the bit length big-endian.
        block_buf[buf_fill] = PAD_BYTE;
        buf_fill++;
        if (buf_fill > LEN_OFFSET)
        begin
            while (buf_fill < BLOCK_BYTES)
            begin
                block_buf[buf_fill] = 8'h00;
                buf_fill++;
            end
            pred_block_rounds();
            buf_fill = 0;
        end
        while (buf_fill < LEN_OFFSET)
        begin
            block_buf[buf_fill] = 8'h00;
            buf_fill++;
        end
        for (i = 0; i < 8; i++)
        begin
            block_buf[LEN_OFFSET + i] = msg_bits[63 - 8*i -: 8];
        end
        pred_block_rounds();
        digest = {hash_state[0], hash_state[1], hash_state[2], hash_state[3], hash_state[4]};
        sha1_restart();
        return 1'b1;
    endfunction

    task automatic note_failure(input string msg);
        error_count++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // Idle and stall mix of each phase of the run.
    task automatic apply_phase(input int unsigned phase);
        case (phase)
            0:
            begin
                src_idle_pct  = 0;
                snk_stall_pct = 0;
            end
            1:
            begin
                src_idle_pct  = 56;
                snk_stall_pct = 0;
            end
            2:
            begin
                src_idle_pct  = 0;
                snk_stall_pct = 56;
            end
            default:
            begin
                src_idle_pct  = 17;
                snk_stall_pct = 17;
            end
        endcase
    endtask

    // Send one input transaction, then queue the digest words it causes.
    task automatic run_item(input logic [7:0] data, input logic has_byte, input logic end_msg,
                            input logic known, input logic [159:0] known_digest);
        logic [159:0] digest;
        digest_word_t dw;
        int unsigned  i;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= has_byte;
        s_axis_tlast  <= end_msg;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        items_sent++;
        if (sha1_take_item(data, has_byte, end_msg, digest))
        begin
            if (known)
            begin
                digest = known_digest;
            end
            for (i = 0; i < DIGEST_WORDS; i++)
            begin
                dw.word = digest[159 - 32*i -: 32];
                dw.pos  = IDX_W'(i);
                dw.last = (i == DIGEST_WORDS - 1);
                pending_words.push_back(dw);
            end
            digests_due++;
        end
    endtask

    // Output side: check each accepted digest word and drive the stall pattern.
    always @(posedge clk)
    begin
        digest_word_t due;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            words_checked++;
            if (pending_words.size() == 0)
            begin
                note_failure($sformatf("unexpected digest word %h", m_axis_tdata));
            end
            else
            begin
                due = pending_words.pop_front();
                if (m_axis_tdata !== due.word)
                begin
                    note_failure($sformatf("digest word %0d: got %h, want %h",
                                           due.pos, m_axis_tdata, due.word));
                end
                if (m_axis_tuser !== due.pos)
                begin
                    note_failure($sformatf("word index: got %0d, want %0d",
                                           m_axis_tuser, due.pos));
                end
                if (m_axis_tlast !== due.last)
                begin
                    note_failure($sformatf("last flag on word %0d: got %b, want %b",
                                           due.pos, m_axis_tlast, due.last));
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Count cycles in which neither side moves a transaction.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : watchdog
        wait (rst_n === 1'b1);
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
        end
        $display("Timeout: no transaction for %0d cycles, %0d digest words outstanding",
                 QUIET_LIMIT, pending_words.size());
        $display("sha1_hash_engine_top_test: done, errors");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned row;
        int unsigned counted;
        int unsigned msg_len;
        int unsigned i;
        int unsigned messages;
        bit          close_on_byte;
        sha1_restart();
        counted  = 0;
        messages = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part.
        apply_phase(3);
        for (row = 0; row < NUM_ROWS; row++)
        begin
            run_item(DIRECTED_ROWS[row].data, DIRECTED_ROWS[row].has_byte,
                     DIRECTED_ROWS[row].end_msg, DIRECTED_ROWS[row].known,
                     DIRECTED_ROWS[row].digest);
        end

        // Random messages, weighted toward lengths that land on the padding edges.
        while (counted < ITEM_TARGET)
        begin
            apply_phase((counted * 4) / ITEM_TARGET);
            case ($urandom_range(9))
                5:       msg_len = $urandom_range(57, 55);
                6:       msg_len = $urandom_range(65, 63);
                7:       msg_len = $urandom_range(130, 110);
                8, 9:    msg_len = $urandom_range(8);
                default: msg_len = $urandom_range(20);
            endcase
            close_on_byte = (msg_len != 0) && ($urandom_range(1) == 1);
            for (i = 0; i < msg_len; i++)
            begin
                // Occasional idle transaction with random data mixed into the message.
                if ($urandom_range(99) < 8)
                begin
                    run_item(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0, '0);
                end
                run_item(8'($urandom_range(255)), 1'b1, close_on_byte && (i == msg_len - 1),
                         1'b0, '0);
                counted++;
            end
            if (!close_on_byte)
            begin
                run_item(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0, '0);
                counted++;
            end
            messages++;
        end
        s_axis_tvalid <= 1'b0;

        // Drain: every digest word must arrive, then nothing more may follow.
        while (pending_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d input transactions (%0d random messages), %0d digests expected.",
                 items_sent, messages, digests_due);
        $display("Checked %0d digest words under mixed source idling and sink stalls.",
                 words_checked);
        if (error_count == 0)
        begin
            $display("sha1_hash_engine_top_test: done, clean");
        end
        else
        begin
            $display("sha1_hash_engine_top_test: done, errors");
        end
        $finish;
    end

endmodule

### sha1_hash_engine_top.f
+incdir+hdl
hdl/sha1he_pkg.sv
hdl/sha1he_sched.sv
hdl/sha1he_round.sv
hdl/sha1_hash_engine_top.sv
dv/sha1_hash_engine_top_test.sv
